FILE: rtl/core/shaic_pkg.sv
// ----------------------------------------------------------------------------
// shaic_pkg
// Shared types and constants for the string key hash / array index classifier.
// ----------------------------------------------------------------------------
package shaic_pkg;

  localparam int unsigned KEY_W  = 32;
  localparam int unsigned UNIT_W = 16;

  localparam logic [KEY_W-1:0]  HASH_SEED  = 32'hffff_ffff;
  localparam logic [KEY_W-1:0]  KEY_MAX    = 32'hffff_ffff;
  localparam logic [UNIT_W-1:0] DIGIT_ZERO = 16'h0030;
  localparam logic [UNIT_W-1:0] DIGIT_MAX  = 16'd9;

  typedef enum logic [1:0] {
    KIND_REGULAR = 2'd0,
    KIND_INDEX   = 2'd1,
    KIND_UINT    = 2'd2
  } key_kind_t;

  typedef struct packed {
    logic             done;
    logic [KEY_W-1:0] key_value;
    key_kind_t        key_kind;
  } key_result_t;

endpackage

FILE: rtl/core/shaic_if.sv
// ----------------------------------------------------------------------------
// shaic_if
// Valid/ready channels for code unit beats and classified key beats.
// ----------------------------------------------------------------------------
interface shaic_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        last_unit;

  modport source (output valid, output code_unit, output last_unit, input ready);
  modport sink   (input valid, input code_unit, input last_unit, output ready);
endinterface

interface shaic_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] key_value;
  logic [1:0]  key_kind;

  modport source (output valid, output key_value, output key_kind, input ready);
  modport sink   (input valid, input key_value, input key_kind, output ready);
endinterface

FILE: rtl/core/shaic_keystate.sv
// ----------------------------------------------------------------------------
// shaic_keystate
// Running hash and decimal index state; classifies the string at its last unit.
// ----------------------------------------------------------------------------
module shaic_keystate (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          advance,
  input  logic [shaic_pkg::UNIT_W-1:0]  code_unit,
  input  logic                          last_unit,
  output shaic_pkg::key_result_t        result
);

  logic [shaic_pkg::KEY_W-1:0] hash_r, hash_nxt, hash_upd;
  logic [shaic_pkg::KEY_W-1:0] num_r, num_nxt, num_upd;
  logic                        dec_r, dec_nxt, dec_upd;
  logic                        first_r, first_nxt;
  logic                        lzero_r, lzero_nxt, lzero_upd;

  logic [shaic_pkg::UNIT_W-1:0] digit;
  logic                         is_digit;
  logic [35:0]                  num_x10;

  always_comb begin
    // h*31 + unit, as (h << 5) - h
    hash_upd = (hash_r << 5) - hash_r + {16'b0, code_unit};

    digit    = code_unit - shaic_pkg::DIGIT_ZERO;
    is_digit = (digit <= shaic_pkg::DIGIT_MAX);
    num_x10  = ({4'b0, num_r} << 3) + ({4'b0, num_r} << 1) + {20'b0, digit};

    num_upd   = num_r;
    dec_upd   = dec_r;
    lzero_upd = lzero_r;
    if (dec_r) begin
      if (!is_digit) begin
        dec_upd = 1'b0;
      end else if (first_r) begin
        num_upd   = {16'b0, digit};
        lzero_upd = (digit == '0);
      end else if (lzero_r) begin
        dec_upd = 1'b0;
      end else if (|num_x10[35:32]) begin
        dec_upd = 1'b0;
      end else begin
        num_upd = num_x10[31:0];
      end
    end

    result.done = last_unit;
    if (dec_upd) begin
      result.key_value = num_upd;
      result.key_kind  = (num_upd == shaic_pkg::KEY_MAX) ? shaic_pkg::KIND_UINT
                                                         : shaic_pkg::KIND_INDEX;
    end else begin
      result.key_value = hash_upd;
      result.key_kind  = shaic_pkg::KIND_REGULAR;
    end

    hash_nxt  = hash_r;
    num_nxt   = num_r;
    dec_nxt   = dec_r;
    first_nxt = first_r;
    lzero_nxt = lzero_r;
    if (advance) begin
      if (last_unit) begin
        // string done: start over for the next one
        hash_nxt  = shaic_pkg::HASH_SEED;
        num_nxt   = '0;
        dec_nxt   = 1'b1;
        first_nxt = 1'b1;
        lzero_nxt = 1'b0;
      end else begin
        hash_nxt  = hash_upd;
        num_nxt   = num_upd;
        dec_nxt   = dec_upd;
        first_nxt = 1'b0;
        lzero_nxt = lzero_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r  <= shaic_pkg::HASH_SEED;
      num_r   <= '0;
      dec_r   <= 1'b1;
      first_r <= 1'b1;
      lzero_r <= 1'b0;
    end else begin
      hash_r  <= hash_nxt;
      num_r   <= num_nxt;
      dec_r   <= dec_nxt;
      first_r <= first_nxt;
      lzero_r <= lzero_nxt;
    end
  end

endmodule

FILE: rtl/core/string_hash_and_array_index_classify_core.sv
// ----------------------------------------------------------------------------
// string_hash_and_array_index_classify_core
// Property-name key classifier: multiplicative hash or decimal array index.
// ----------------------------------------------------------------------------
// Takes one code unit per cycle, back to back, with no gaps needed between
// strings. The key for a string appears on the output in the cycle after the beat
// carrying its last unit, from the output register. The output register lets
// the input keep flowing while a key waits, and input ready drops only when
// that register is full and not being taken.
module string_hash_and_array_index_classify_core (
  input  logic              clk,
  input  logic              rst_n,
  shaic_in_if.sink          in_ch,
  shaic_out_if.source       out_ch
);

  logic                   in_fire;
  shaic_pkg::key_result_t step_res;

  logic                   out_valid_r, out_valid_nxt;
  logic [31:0]            key_value_r;
  shaic_pkg::key_kind_t   key_kind_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  shaic_keystate u_keystate (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (in_fire),
    .code_unit (in_ch.code_unit),
    .last_unit (in_ch.last_unit),
    .result    (step_res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire && step_res.done) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // load the key beat when a string closes
  always_ff @(posedge clk) begin
    if (in_fire && step_res.done) begin
      key_value_r <= step_res.key_value;
      key_kind_r  <= step_res.key_kind;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.key_value = key_value_r;
  assign out_ch.key_kind  = 2'(key_kind_r);

endmodule

FILE: rtl/core/shaic_checker.sv
// ----------------------------------------------------------------------------
// shaic_checker
// Port-level checks for the key classifier, bound to the top level.
// ----------------------------------------------------------------------------
module shaic_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last_unit,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_key_value,
  input logic [1:0]  out_key_kind
);

  logic in_fire;
  logic out_stall;

  assign in_fire   = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;

  // a stalled key beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_stall |=> out_valid && $stable(out_key_value) && $stable(out_key_kind))
    else $error("key beat changed while stalled");

  a_last_gives_key: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_last_unit |=> out_valid)
    else $error("no key beat after last unit");

  a_mid_no_key: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_last_unit && !out_stall |=> !out_valid)
    else $error("key beat without last unit");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_key_kind != 2'd3)
    else $error("illegal key kind");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_key_kind == 2'(shaic_pkg::KIND_INDEX) |->
      out_key_value != shaic_pkg::KEY_MAX)
    else $error("array index equals max value");

endmodule

bind string_hash_and_array_index_classify_core shaic_checker u_shaic_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_last_unit  (in_ch.last_unit),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_key_value (out_ch.key_value),
  .out_key_kind  (out_ch.key_kind)
);
